[design/clru_pkg.sv]
// Shared types and defaults for the counter-based LRU victim select unit.
// Has no dependencies; the other design files except clru_ram refer to it by scoped names.
package clru_pkg;

    localparam int SET_COUNT_DEFAULT = 1024;
    localparam int WAY_COUNT_DEFAULT = 8;

    localparam int SET_IDX_W = 10;
    localparam int WAY_IDX_W = 3;
    localparam int MASK_W    = 8;

    localparam logic CMD_TOUCH  = 1'b0;
    localparam logic CMD_CHOOSE = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_IDX_W-1:0] way;
        logic [MASK_W-1:0]    invalid_mask;
    } t_in_item;

    typedef struct packed {
        logic [WAY_IDX_W-1:0] victim_way;
        logic                 victim_invalid;
    } t_out_item;

endpackage

[design/clru_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module clru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/clru_row_logic.sv]
// Combinational update and victim search on one set's row of rank counters.
// Depends on clru_pkg for the field widths and the result item type.
module clru_row_logic #(
    parameter int WAY_COUNT = clru_pkg::WAY_COUNT_DEFAULT,
    parameter int RANK_W = $clog2(WAY_COUNT),
    parameter int ROW_W = WAY_COUNT * RANK_W
) (
    input  logic [ROW_W-1:0]               i_row,
    input  logic [clru_pkg::WAY_IDX_W-1:0] i_way,
    input  logic [clru_pkg::MASK_W-1:0]    i_mask,
    output logic [ROW_W-1:0]               o_row,
    output logic                           o_touch_ok,
    output clru_pkg::t_out_item            o_victim
);

    // Only the ways that own a mask bit can be reported invalid.
    localparam int MASK_WAYS = (WAY_COUNT < clru_pkg::MASK_W) ? WAY_COUNT : clru_pkg::MASK_W;

    logic [RANK_W-1:0] ranks [WAY_COUNT];
    logic [RANK_W-1:0] cur_rank;
    logic              found;
    logic [RANK_W-1:0] best;
    logic [RANK_W-1:0] best_rank;
    logic [RANK_W-1:0] lru;
    logic [RANK_W-1:0] pick;

    always_comb begin
        for (int i = 0; i < WAY_COUNT; i++) begin
            ranks[i] = i_row[i*RANK_W +: RANK_W];
        end
    end

    assign o_touch_ok = (int'(i_way) < WAY_COUNT);

    always_comb begin
        cur_rank = '0;
        for (int i = 0; i < WAY_COUNT; i++) begin
            if (int'(i_way) == i) begin
                cur_rank = ranks[i];
            end
        end
        for (int i = 0; i < WAY_COUNT; i++) begin
            if (int'(i_way) == i) begin
                o_row[i*RANK_W +: RANK_W] = RANK_W'(WAY_COUNT - 1);
            end else if (ranks[i] > cur_rank) begin
                o_row[i*RANK_W +: RANK_W] = ranks[i] - 1'b1;
            end else begin
                o_row[i*RANK_W +: RANK_W] = ranks[i];
            end
        end
    end

    always_comb begin
        found     = 1'b0;
        best      = '0;
        best_rank = '0;
        for (int i = 0; i < MASK_WAYS; i++) begin
            if (i_mask[i] && (!found || (ranks[i] < best_rank))) begin
                found     = 1'b1;
                best      = RANK_W'(i);
                best_rank = ranks[i];
            end
        end
        // Scan downward so the lowest way holding rank zero wins.
        lru = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--) begin
            if (ranks[i] == '0) begin
                lru = RANK_W'(i);
            end
        end
        pick = found ? best : lru;
        o_victim.victim_way     = clru_pkg::WAY_IDX_W'(pick);
        o_victim.victim_invalid = found;
    end

endmodule

[design/counter_lru_victim_select_unit.sv]
// Top level of the counter-based true-LRU victim select unit.
// Depends on clru_pkg, clru_ram and clru_row_logic.
//
//   Channel   Direction  Valid        Stall        Payload
//   input     in         i_in_valid   o_in_stall   i_in_data  (clru_pkg::t_in_item)
//   output    out        o_out_valid  i_out_stall  o_out_data (clru_pkg::t_out_item)
//
// In the transfer cycle of a command the set's row of rank counters is read from
// the rank RAM, whose read is registered, and in ST_EXEC the row logic either
// writes the updated row back (touch) or loads the victim into the output register
// (choose). Only one command is in flight at a time; no new command is taken until
// ST_EXEC finishes.
// A choose waits in ST_EXEC while the output register is full and stalled.
// After reset a clearing pass writes the initial ranks into every set; no input is
// taken during it.
// Touch commands produce no transfer on the output channel.
module counter_lru_victim_select_unit #(
    parameter int SET_COUNT = clru_pkg::SET_COUNT_DEFAULT,
    parameter int WAY_COUNT = clru_pkg::WAY_COUNT_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clru_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clru_pkg::t_out_item o_out_data
);

    localparam int RANK_W = $clog2(WAY_COUNT);
    localparam int ROW_W  = WAY_COUNT * RANK_W;
    localparam int ADDR_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

    // Initial row: way w holds rank w.
    function automatic logic [ROW_W-1:0] init_row();
        logic [ROW_W-1:0] r;
        for (int w = 0; w < WAY_COUNT; w++) begin
            r[w*RANK_W +: RANK_W] = RANK_W'(w);
        end
        return r;
    endfunction

    localparam logic [ROW_W-1:0] INIT_ROW = init_row();
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SET_COUNT - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    clru_pkg::t_in_item  r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_out_valid;
    clru_pkg::t_out_item r_out_item;

    logic                     in_xfer;
    logic                     out_free;
    logic [clru_pkg::SET_IDX_W-1:0] set_mod;
    logic [ADDR_W-1:0]        set_addr;
    logic [ROW_W-1:0]         rd_row;
    logic [ROW_W-1:0]         upd_row;
    logic                     touch_ok;
    clru_pkg::t_out_item      victim;
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [ROW_W-1:0]         ram_wr_data;
    logic                     exec_done;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // The set index is reduced modulo SET_COUNT by conditional subtraction of
    // shifted copies of the constant, most significant first.
    always_comb begin
        set_mod = i_in_data.set_index;
        for (int k = clru_pkg::SET_IDX_W - 1; k >= 0; k--) begin
            if (longint'(set_mod) >= (longint'(SET_COUNT) << k)) begin
                set_mod = clru_pkg::SET_IDX_W'(longint'(set_mod) - (longint'(SET_COUNT) << k));
            end
        end
        set_addr = ADDR_W'(set_mod);
    end

    // A touch finishes at once; a choose finishes when the output register can take it.
    assign exec_done = (r_state == ST_EXEC)
                    && ((r_cmd.command == clru_pkg::CMD_TOUCH) || out_free);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = INIT_ROW;
        end else begin
            ram_wr_en   = (r_state == ST_EXEC) && (r_cmd.command == clru_pkg::CMD_TOUCH)
                       && touch_ok;
            ram_wr_addr = r_addr;
            ram_wr_data = upd_row;
        end
    end

    clru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT),
        .ADDR_W(ADDR_W)
    ) u_rank_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(set_addr),
        .o_rd_data(rd_row)
    );

    clru_row_logic #(
        .WAY_COUNT(WAY_COUNT),
        .RANK_W   (RANK_W),
        .ROW_W    (ROW_W)
    ) u_row_logic (
        .i_row     (rd_row),
        .i_way     (r_cmd.way),
        .i_mask    (r_cmd.invalid_mask),
        .o_row     (upd_row),
        .o_touch_ok(touch_ok),
        .o_victim  (victim)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A finishing choose refills the output register in the same cycle
            // that a waiting result leaves it.
            if (exec_done && (r_cmd.command == clru_pkg::CMD_CHOOSE)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_in_data;
            r_addr <= set_addr;
        end
        if (exec_done && (r_cmd.command == clru_pkg::CMD_CHOOSE)) begin
            r_out_item <= victim;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

[design/clru_checker.sv]
// Port-level checker for the counter-based LRU victim select unit, with its bind.
// Depends on clru_pkg and on counter_lru_victim_select_unit.
module clru_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input clru_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input clru_pkg::t_out_item o_out_data
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // One command at a time: the cycle after a transfer in is stalled.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a command is in flight");

    // A new result appears only where a choose was taken before it.
    a_result_from_choose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall
            && (i_in_data.command == clru_pkg::CMD_CHOOSE), 2))
        else $error("result without a matching choose");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind counter_lru_victim_select_unit clru_checker u_clru_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
